// File: hw/rtl/bcdt_pkg.sv
// shared types and constants for the bcd clock and calendar adjuster
package bcdt_pkg;

  // item function codes
  typedef enum logic [2:0] {
    FUNC_LOAD  = 3'd0,
    FUNC_SEC   = 3'd1,
    FUNC_MIN   = 3'd2,
    FUNC_HOUR  = 3'd3,
    FUNC_DAY   = 3'd4,
    FUNC_MONTH = 3'd5,
    FUNC_YEAR  = 3'd6
  } func_t;

  // field ranges in packed bcd
  localparam logic [7:0] BCD_ZERO     = 8'h00;
  localparam logic [7:0] BCD_ONE      = 8'h01;
  localparam logic [7:0] SEC_MIN_HI   = 8'h59;
  localparam logic [7:0] HOUR_HI      = 8'h23;
  localparam logic [7:0] MONTH_HI     = 8'h12;
  localparam logic [7:0] YEAR_HI      = 8'h99;
  localparam logic [7:0] CENTURY_RST  = 8'h20;
  localparam logic [7:0] DAYS_LONG    = 8'h31;
  localparam logic [7:0] DAYS_SHORT   = 8'h30;
  localparam logic [7:0] DAYS_FEB     = 8'h28;
  localparam logic [7:0] DAYS_FEB_LP  = 8'h29;
  localparam logic [7:0] MONTH_FEB    = 8'h02;
  localparam logic [7:0] MONTH_APR    = 8'h04;
  localparam logic [7:0] MONTH_JUN    = 8'h06;
  localparam logic [7:0] MONTH_SEP    = 8'h09;
  localparam logic [7:0] MONTH_NOV    = 8'h11;

  // input item
  typedef struct packed {
    func_t      func;
    logic       down;
    logic [7:0] load_sec;
    logic [7:0] load_min;
    logic [7:0] load_hour;
    logic [7:0] load_day;
    logic [7:0] load_month;
    logic [7:0] load_year;
    logic [7:0] load_century;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] sec_out;
    logic [7:0] min_out;
    logic [7:0] hour_out;
    logic [7:0] day_out;
    logic [7:0] month_out;
    logic [7:0] year_out;
    logic [7:0] century_out;
  } out_item_t;

  // held clock and calendar
  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
  } bcd_clk_t;

endpackage

// File: hw/rtl/bcdt_step.sv
// one packed-bcd up/down step with wrap over a lo..hi range
module bcdt_step (
  input  logic [7:0] v,
  input  logic [7:0] lo,
  input  logic [7:0] hi,
  input  logic       down,
  output logic [7:0] res
);

  logic [3:0] units;
  logic [3:0] tens;

  assign units = v[3:0];
  assign tens  = v[7:4];

  // increment wraps to lo, decrement wraps to hi; bad units digits are repaired
  always_comb begin
    if (!down) begin
      if ((v >= hi) || (v < lo)) begin
        res = lo;
      end else if (units >= 4'd9) begin
        res = {tens + 4'd1, 4'h0};
      end else begin
        res = v + 8'd1;
      end
    end else begin
      if ((v <= lo) || (v > hi)) begin
        res = hi;
      end else if (units == 4'd0) begin
        res = {tens - 4'd1, 4'h9};
      end else if (units > 4'd9) begin
        res = {tens, 4'h9};
      end else begin
        res = v - 8'd1;
      end
    end
  end

endmodule

// File: hw/rtl/bcdt_update.sv
// next clock value from the current clock and one item
module bcdt_update (
  input  bcdt_pkg::bcd_clk_t cur,
  input  bcdt_pkg::in_item_t item,
  output bcdt_pkg::bcd_clk_t nxt
);

  logic [7:0] sel_v;
  logic [7:0] sel_lo;
  logic [7:0] sel_hi;
  logic [7:0] step_res;
  logic [7:0] cent_res;
  logic [7:0] mdays;
  logic       leap;
  logic [1:0] yr_mod4;
  logic       yr_carry;

  // year mod 4 from bcd digits: 10*t + u == 2*t + u (mod 4)
  assign yr_mod4 = cur.year[1:0] + {cur.year[4], 1'b0};
  assign leap    = (yr_mod4 == 2'd0);

  // days in the current month
  always_comb begin
    if ((cur.month == bcdt_pkg::MONTH_APR) || (cur.month == bcdt_pkg::MONTH_JUN) ||
        (cur.month == bcdt_pkg::MONTH_SEP) || (cur.month == bcdt_pkg::MONTH_NOV)) begin
      mdays = bcdt_pkg::DAYS_SHORT;
    end else if (cur.month == bcdt_pkg::MONTH_FEB) begin
      mdays = leap ? bcdt_pkg::DAYS_FEB_LP : bcdt_pkg::DAYS_FEB;
    end else begin
      mdays = bcdt_pkg::DAYS_LONG;
    end
  end

  // pick the field to step and its range
  always_comb begin
    sel_v  = cur.sec;
    sel_lo = bcdt_pkg::BCD_ZERO;
    sel_hi = bcdt_pkg::SEC_MIN_HI;
    unique case (item.func)
      bcdt_pkg::FUNC_MIN: begin
        sel_v = cur.min;
      end
      bcdt_pkg::FUNC_HOUR: begin
        sel_v  = cur.hour;
        sel_hi = bcdt_pkg::HOUR_HI;
      end
      bcdt_pkg::FUNC_DAY: begin
        sel_v  = cur.day;
        sel_lo = bcdt_pkg::BCD_ONE;
        sel_hi = mdays;
      end
      bcdt_pkg::FUNC_MONTH: begin
        sel_v  = cur.month;
        sel_lo = bcdt_pkg::BCD_ONE;
        sel_hi = bcdt_pkg::MONTH_HI;
      end
      bcdt_pkg::FUNC_YEAR: begin
        sel_v  = cur.year;
        sel_hi = bcdt_pkg::YEAR_HI;
      end
      default: begin
        sel_v = cur.sec;
      end
    endcase
  end

  bcdt_step u_field_step (
    .v    (sel_v),
    .lo   (sel_lo),
    .hi   (sel_hi),
    .down (item.down),
    .res  (step_res)
  );

  bcdt_step u_cent_step (
    .v    (cur.century),
    .lo   (bcdt_pkg::BCD_ZERO),
    .hi   (bcdt_pkg::YEAR_HI),
    .down (item.down),
    .res  (cent_res)
  );

  // century moves only on a real 99/00 rollover
  assign yr_carry = item.down ? (cur.year == bcdt_pkg::BCD_ZERO)
                              : (cur.year == bcdt_pkg::YEAR_HI);

  // write back the stepped field
  always_comb begin
    nxt = cur;
    unique case (item.func)
      bcdt_pkg::FUNC_LOAD: begin
        nxt.sec     = item.load_sec;
        nxt.min     = item.load_min;
        nxt.hour    = item.load_hour;
        nxt.day     = item.load_day;
        nxt.month   = item.load_month;
        nxt.year    = item.load_year;
        nxt.century = item.load_century;
      end
      bcdt_pkg::FUNC_SEC:   nxt.sec   = step_res;
      bcdt_pkg::FUNC_MIN:   nxt.min   = step_res;
      bcdt_pkg::FUNC_HOUR:  nxt.hour  = step_res;
      bcdt_pkg::FUNC_DAY:   nxt.day   = step_res;
      bcdt_pkg::FUNC_MONTH: nxt.month = step_res;
      bcdt_pkg::FUNC_YEAR: begin
        nxt.year = step_res;
        if (yr_carry) begin
          nxt.century = cent_res;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: hw/rtl/bcd_date_time_setter_unit.sv
// Packed-BCD clock and calendar adjuster. Each item either loads all seven
// fields (seconds, minutes, hours, day, month, two-digit year, century) or
// steps one field up or down by one, and returns the whole clock after the
// item. An item is taken into an input register, then one pass of bcd step
// logic updates the held clock and the result register at the same edge, so
// one item is accepted every cycle while the receiver does not stall the
// result. After reset the clock reads 20 00-00-00 00:00:00.
// Unused function codes leave the clock unchanged and still return a result.
module bcd_date_time_setter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcdt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bcdt_pkg::out_item_t out_item
);

  bcdt_pkg::in_item_t  item_r;
  logic                item_vld_r;
  bcdt_pkg::bcd_clk_t  state_r;
  bcdt_pkg::bcd_clk_t  state_nxt;
  bcdt_pkg::out_item_t out_r;
  logic                out_vld_r;
  logic                adv;
  logic                in_acc;

  // handshake control
  assign adv       = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = item_vld_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  bcdt_update u_update (
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt)
  );

  // valid bits and held clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      state_r    <= {{6{bcdt_pkg::BCD_ZERO}}, bcdt_pkg::CENTURY_RST};
    end else begin
      if (in_acc) begin
        item_vld_r <= 1'b1;
      end else if (adv) begin
        item_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    if (adv) begin
      out_r <= {state_nxt.sec, state_nxt.min, state_nxt.hour, state_nxt.day,
                state_nxt.month, state_nxt.year, state_nxt.century};
    end
  end

`ifndef SYNTH
  // a held result always mirrors the current clock
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r == {state_r.sec, state_r.min, state_r.hour, state_r.day,
                             state_r.month, state_r.year, state_r.century}))
    else $error("result register differs from held clock");

  // stall only while an item is waiting
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_vld_r)
    else $error("input stalled with empty input register");

  // clock frozen while the result is held back
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> $stable(state_r))
    else $error("clock changed while result stalled");

  // only load and year items touch the century
  a_century_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (item_r.func != bcdt_pkg::FUNC_LOAD) && (item_r.func != bcdt_pkg::FUNC_YEAR))
    |=> (state_r.century == $past(state_r.century)))
    else $error("century changed by a non-year step");
`endif

endmodule

// File: verif/tb_bcd_date_time_setter_unit.sv
// testbench for the packed-bcd clock and calendar adjuster, checked against a shadow clock
module tb_bcd_date_time_setter_unit;

  // unused function code, leaves the clock alone
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  localparam int NUM_RANDOM  = 1625;
  localparam int BLOCK_LEN   = 100;
  localparam int PRESS_ITEM  = 500;
  localparam int LONG_HOLD   = 200;
  localparam int WDOG_LIMIT  = 2000;
  localparam int DRAIN_CYC   = 8;

  localparam bcdt_pkg::bcd_clk_t NO_CLK  = '0;
  localparam bcdt_pkg::bcd_clk_t RST_CLK = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                             bcdt_pkg::CENTURY_RST};
  localparam bcdt_pkg::bcd_clk_t TOP_CLK = '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99};

  typedef struct {
    bcdt_pkg::func_t    func;
    bit                 dn;
    bcdt_pkg::bcd_clk_t ld;
    bit                 pin;
    bcdt_pkg::bcd_clk_t want;
  } dir_row_t;

  typedef struct {
    bit                 on;
    bcdt_pkg::bcd_clk_t val;
  } pinned_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bcdt_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bcdt_pkg::out_item_t out_item;

  bcdt_pkg::bcd_clk_t  shadow_clock;
  bcdt_pkg::bcd_clk_t  pending_clocks[$];
  pinned_t             pinned_q[$];
  bit        calm     = 1'b0;
  bit        hold_req = 1'b0;
  int        mism     = 0;
  int        idle_cyc = 0;
  int        n_in     = 0;
  int        n_out    = 0;
  int        n_load   = 0;

  // directed items: extremes, wraps, bad digits, out-of-range values, day overhang
  dir_row_t dir_tab [26] = '{
    '{bcdt_pkg::func_t'(FUNC_UNUSED), 1'b0, NO_CLK, 1'b1, RST_CLK},
    '{bcdt_pkg::FUNC_SEC,   1'b1, NO_CLK, 1'b1,
      '{8'h59, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, bcdt_pkg::CENTURY_RST}},
    '{bcdt_pkg::FUNC_LOAD,  1'b0, TOP_CLK, 1'b1, TOP_CLK},
    '{bcdt_pkg::FUNC_SEC,   1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_MIN,   1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_HOUR,  1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_DAY,   1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_MONTH, 1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_YEAR,  1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_YEAR,  1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_LOAD,  1'b0, '{8'h1A, 8'h60, 8'h99, 8'h31, 8'h01, 8'h03, 8'h00}, 1'b1,
      '{8'h1A, 8'h60, 8'h99, 8'h31, 8'h01, 8'h03, 8'h00}},
    '{bcdt_pkg::FUNC_SEC,   1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_MIN,   1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_HOUR,  1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_MONTH, 1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_DAY,   1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_LOAD,  1'b0, '{8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h04, 8'h00}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h04, 8'h00}},
    '{bcdt_pkg::FUNC_DAY,   1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_LOAD,  1'b0, '{8'h0A, 8'h00, 8'h00, 8'h30, 8'h13, 8'h3A, 8'h00}, 1'b1,
      '{8'h0A, 8'h00, 8'h00, 8'h30, 8'h13, 8'h3A, 8'h00}},
    '{bcdt_pkg::FUNC_DAY,   1'b0, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_MONTH, 1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_YEAR,  1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_SEC,   1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_LOAD,  1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00}},
    '{bcdt_pkg::FUNC_MONTH, 1'b1, NO_CLK, 1'b0, NO_CLK},
    '{bcdt_pkg::FUNC_YEAR,  1'b1, NO_CLK, 1'b0, NO_CLK}
  };

  bcd_date_time_setter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one bcd step with wrap, clamping bad digits and out-of-range values
  function automatic logic [7:0] bcd_bump(logic [7:0] v, logic [7:0] lo, logic [7:0] hi,
                                          bit dn);
    logic [3:0] u;
    u = v[3:0];
    if (!dn) begin
      if (v >= hi || v < lo) return lo;
      if (u >= 4'd9) return {v[7:4], 4'h0} + 8'h10;
      return v + 8'h01;
    end
    if (v <= lo || v > hi) return hi;
    if (u == 4'd0) return ({v[7:4], 4'h0} - 8'h10) | 8'h09;
    if (u > 4'd9) return {v[7:4], 4'h9};
    return v - 8'h01;
  endfunction

  // length of the month as bcd, leap every fourth year
  function automatic logic [7:0] month_len(logic [7:0] month, logic [7:0] year);
    int yv;
    yv = int'(year[7:4]) * 10 + int'(year[3:0]);
    case (month) inside
      bcdt_pkg::MONTH_APR, bcdt_pkg::MONTH_JUN, bcdt_pkg::MONTH_SEP,
      bcdt_pkg::MONTH_NOV: return bcdt_pkg::DAYS_SHORT;
      bcdt_pkg::MONTH_FEB: return (yv % 4 == 0) ? bcdt_pkg::DAYS_FEB_LP : bcdt_pkg::DAYS_FEB;
      default: return bcdt_pkg::DAYS_LONG;
    endcase
  endfunction

  // clock after one item
  function automatic bcdt_pkg::bcd_clk_t advance_clock(bcdt_pkg::bcd_clk_t c,
                                                       bcdt_pkg::in_item_t it);
    bit carry;
    case (it.func)
      bcdt_pkg::FUNC_LOAD: begin
        c = '{it.load_sec, it.load_min, it.load_hour, it.load_day, it.load_month,
              it.load_year, it.load_century};
      end
      bcdt_pkg::FUNC_SEC:
        c.sec   = bcd_bump(c.sec, bcdt_pkg::BCD_ZERO, bcdt_pkg::SEC_MIN_HI, it.down);
      bcdt_pkg::FUNC_MIN:
        c.min   = bcd_bump(c.min, bcdt_pkg::BCD_ZERO, bcdt_pkg::SEC_MIN_HI, it.down);
      bcdt_pkg::FUNC_HOUR:
        c.hour  = bcd_bump(c.hour, bcdt_pkg::BCD_ZERO, bcdt_pkg::HOUR_HI, it.down);
      bcdt_pkg::FUNC_DAY:
        c.day   = bcd_bump(c.day, bcdt_pkg::BCD_ONE, month_len(c.month, c.year), it.down);
      bcdt_pkg::FUNC_MONTH:
        c.month = bcd_bump(c.month, bcdt_pkg::BCD_ONE, bcdt_pkg::MONTH_HI, it.down);
      bcdt_pkg::FUNC_YEAR: begin
        carry  = it.down ? (c.year == bcdt_pkg::BCD_ZERO) : (c.year == bcdt_pkg::YEAR_HI);
        c.year = bcd_bump(c.year, bcdt_pkg::BCD_ZERO, bcdt_pkg::YEAR_HI, it.down);
        if (carry) begin
          c.century = bcd_bump(c.century, bcdt_pkg::BCD_ZERO, bcdt_pkg::YEAR_HI, it.down);
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic bcdt_pkg::in_item_t make_item(bcdt_pkg::func_t f, bit dn,
                                                   bcdt_pkg::bcd_clk_t ld);
    bcdt_pkg::in_item_t it;
    it.func         = f;
    it.down         = dn;
    it.load_sec     = ld.sec;
    it.load_min     = ld.min;
    it.load_hour    = ld.hour;
    it.load_day     = ld.day;
    it.load_month   = ld.month;
    it.load_year    = ld.year;
    it.load_century = ld.century;
    return it;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // valid bcd in a decimal range, ends of the range favored
  function automatic logic [7:0] rim_bcd(int lo, int hi);
    int n;
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: n = lo;
      1: n = hi;
      default: n = $urandom_range(lo, hi);
    endcase
    b[7:4] = 4'(n / 10);
    b[3:0] = 4'(n % 10);
    return b;
  endfunction

  function automatic bcdt_pkg::bcd_clk_t sane_clock();
    bcdt_pkg::bcd_clk_t c;
    c.sec     = rim_bcd(0, 59);
    c.min     = rim_bcd(0, 59);
    c.hour    = rim_bcd(0, 23);
    c.day     = rim_bcd(1, 31);
    c.month   = ($urandom_range(0, 3) == 0) ? bcdt_pkg::MONTH_FEB : rim_bcd(1, 12);
    c.year    = rim_bcd(0, 99);
    c.century = rim_bcd(0, 99);
    return c;
  endfunction

  // any byte from 8'h00 to 8'h99 in every field, bad digits included
  function automatic bcdt_pkg::bcd_clk_t noisy_clock();
    bcdt_pkg::bcd_clk_t c;
    c.sec     = 8'($urandom_range(0, 153));
    c.min     = 8'($urandom_range(0, 153));
    c.hour    = 8'($urandom_range(0, 153));
    c.day     = 8'($urandom_range(0, 153));
    c.month   = 8'($urandom_range(0, 153));
    c.year    = 8'($urandom_range(0, 153));
    c.century = 8'($urandom_range(0, 153));
    return c;
  endfunction

  function automatic bcdt_pkg::in_item_t rand_item();
    int r;
    bcdt_pkg::func_t f;
    bcdt_pkg::bcd_clk_t ld;
    r  = $urandom_range(0, 99);
    ld = noisy_clock();
    if (r < 14) begin
      f = bcdt_pkg::FUNC_LOAD;
      if ($urandom_range(0, 9) < 7) ld = sane_clock();
    end else if (r < 17) begin
      f = bcdt_pkg::func_t'(FUNC_UNUSED);
    end else begin
      f = bcdt_pkg::func_t'($urandom_range(1, 6));
    end
    return make_item(f, 1'($urandom_range(0, 1)), ld);
  endfunction

  // offer one item after an optional gap and wait until it is taken
  task automatic offer_item(input bcdt_pkg::in_item_t it, input bit pin_on,
                            input bcdt_pkg::bcd_clk_t pin_val);
    int gap;
    pinned_t p;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.on  = pin_on;
    p.val = pin_val;
    pinned_q.push_back(p);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic check_byte(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", fname, want, got);
      mism++;
    end
  endtask

  // predict on accepted items, compare accepted results, count idle cycles
  always @(posedge clk) begin : monitor
    bcdt_pkg::bcd_clk_t nxt;
    bcdt_pkg::bcd_clk_t want;
    pinned_t p;
    bit moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      nxt          = advance_clock(shadow_clock, in_item);
      shadow_clock = nxt;
      p            = pinned_q.pop_front();
      pending_clocks.push_back(p.on ? p.val : nxt);
      if (in_item.func == bcdt_pkg::FUNC_LOAD) n_load++;
      n_in++;
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      n_out++;
      if (pending_clocks.size() == 0) begin
        $error("result item with no pending expectation");
        mism++;
      end else begin
        want = pending_clocks.pop_front();
        check_byte("sec_out", want.sec, out_item.sec_out);
        check_byte("min_out", want.min, out_item.min_out);
        check_byte("hour_out", want.hour, out_item.hour_out);
        check_byte("day_out", want.day, out_item.day_out);
        check_byte("month_out", want.month, out_item.month_out);
        check_byte("year_out", want.year, out_item.year_out);
        check_byte("century_out", want.century, out_item.century_out);
      end
    end
    idle_cyc = moved ? 0 : idle_cyc + 1;
  end

  // receiver stalls, plus one long hold-off on request
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  initial begin : watchdog
    wait (idle_cyc >= WDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // reset, directed items, random items, drain, verdict
  initial begin : stimulus
    shadow_clock = RST_CLK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      offer_item(make_item(dir_tab[i].func, dir_tab[i].dn, dir_tab[i].ld),
                 dir_tab[i].pin, dir_tab[i].want);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = ((i / BLOCK_LEN) % 4 == 3) || (i / BLOCK_LEN == PRESS_ITEM / BLOCK_LEN);
      if (i == PRESS_ITEM) hold_req = 1'b1;
      offer_item(rand_item(), 1'b0, NO_CLK);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_clocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("summary: %0d items taken (%0d directed, %0d loads), %0d results compared",
             n_in, $size(dir_tab), n_load, n_out);
    $display("summary: %0d field mismatches, one long receiver hold-off", mism);
    if (mism == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bcdt_pkg.sv
hw/rtl/bcdt_step.sv
hw/rtl/bcdt_update.sv
hw/rtl/bcd_date_time_setter_unit.sv
verif/tb_bcd_date_time_setter_unit.sv
